@@ rtl/dms_pkg.sv @@
// Shared types and constants for the deduplicating membership stack.
`default_nettype none

package dms_pkg;

  localparam int SET_SIZE = 1024;
  localparam int ELEM_W = 10;
  localparam int ADDR_W = $clog2(SET_SIZE);
  localparam int DEPTH_W = ADDR_W + 1;

  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_POP = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;
  localparam logic [1:0] ACT_RSVD = 2'd3;

  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_DUP = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic              data;
  } flag_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [ELEM_W-1:0] data;
  } stack_wr_t;

endpackage

`default_nettype wire

@@ rtl/dms_flag_mem.sv @@
// Membership bit memory, one bit per element index, with a registered read port.
`default_nettype none

module dms_flag_mem
  import dms_pkg::*;
(
  input  wire logic              clk,
  input  wire flag_wr_t          wr,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic                   rd_data
);

  logic mem [SET_SIZE];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/dms_stack_mem.sv @@
// Stack entry memory holding element indices, with a registered read port.
`default_nettype none

module dms_stack_mem
  import dms_pkg::*;
(
  input  wire logic              clk,
  input  wire stack_wr_t         wr,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic [ELEM_W-1:0]      rd_data
);

  logic [ELEM_W-1:0] mem [SET_SIZE];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/dedup_membership_stack.sv @@
// Top level of the deduplicating membership stack with its control sequencer.
// Usage: each input transaction carries an action in s_tuser (push, pop or
// query) and an element index in s_tdata. Each one yields exactly one output
// transaction carrying the popped element, the membership bit of the element
// and the stack depth after the operation in m_tdata, and a status in m_tuser.
// Sequence: a push, a query or a successful pop reads the membership and
// stack memories at acceptance, then in the lookup state updates them and the
// depth and loads the output register. A pop on an empty stack presents its
// result in the cycle after acceptance. Flow: the lookup state accepts no
// transaction, due to the read-modify-write of the membership and stack
// memories, each with a single read port. Pops on an empty stack write no
// memory and, while m_tready is high, can follow one per cycle.
// Reset: rst clears the depth and starts a clearing pass over every entry of
// the membership memory; s_tready stays low during the pass.
// Stalls: the result waits in the output register while m_tready is low; a
// new transaction is accepted only once the held result is being taken.
`default_nettype none

module dedup_membership_stack
  import dms_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [9:0] element, [15:10] zero
  input  wire logic [1:0]  s_tuser,   // [1:0] action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [9:0] popped_element, [10] is_member,
                                      // [21:11] depth_now, [23:22] zero
  output logic [1:0]       m_tuser    // [1:0] status
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_LOOK = 2'd2;

  logic [1:0]         state;
  logic [ADDR_W-1:0]  clr_addr;
  logic [DEPTH_W-1:0] top;
  logic [DEPTH_W-1:0] top_next;
  logic [DEPTH_W-1:0] top_dec;
  logic [1:0]         act;
  logic [ELEM_W-1:0]  elem;
  logic [ELEM_W-1:0]  in_elem;

  logic [ELEM_W-1:0]  popped;
  logic               is_member;
  logic [DEPTH_W-1:0] depth;
  logic [1:0]         status;

  logic [ELEM_W-1:0]  popped_next;
  logic               is_member_next;
  logic [1:0]         status_next;

  logic               accept;
  logic               empty_pop;
  logic               out_load;
  logic               flag_rd_data;
  logic [ELEM_W-1:0]  stack_rd_data;
  flag_wr_t           flag_wr;
  stack_wr_t          stack_wr;

  assign in_elem = s_tdata[ELEM_W-1:0];
  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept = s_tvalid && s_tready;
  assign empty_pop = (s_tuser == ACT_POP) && (top == '0);
  assign out_load = (accept && empty_pop) || (state == ST_LOOK);
  assign top_dec = top - DEPTH_W'(1);

  assign m_tdata = {2'b00, depth, is_member, popped};
  assign m_tuser = status;

  dms_flag_mem u_flag_mem (
    .clk     (clk),
    .wr      (flag_wr),
    .rd_en   (accept),
    .rd_addr (in_elem[ADDR_W-1:0]),
    .rd_data (flag_rd_data)
  );

  dms_stack_mem u_stack_mem (
    .clk     (clk),
    .wr      (stack_wr),
    .rd_en   (accept),
    .rd_addr (top_dec[ADDR_W-1:0]),
    .rd_data (stack_rd_data)
  );

  always_comb begin
    flag_wr = '0;
    stack_wr = '0;
    top_next = top;
    popped_next = '0;
    is_member_next = 1'b0;
    status_next = STAT_OK;
    if (state == ST_CLEAR) begin
      flag_wr.en = 1'b1;
      flag_wr.addr = clr_addr;
      flag_wr.data = 1'b0;
    end else if (state == ST_LOOK) begin
      unique case (act) inside
        ACT_PUSH: begin
          if (!flag_rd_data && (top != DEPTH_W'(SET_SIZE))) begin
            flag_wr.en = 1'b1;
            flag_wr.addr = elem[ADDR_W-1:0];
            flag_wr.data = 1'b1;
            stack_wr.en = 1'b1;
            stack_wr.addr = top[ADDR_W-1:0];
            stack_wr.data = elem;
            top_next = top + DEPTH_W'(1);
            is_member_next = 1'b1;
          end else begin
            status_next = STAT_DUP;
            is_member_next = flag_rd_data;
          end
        end
        ACT_POP: begin
          flag_wr.en = 1'b1;
          flag_wr.addr = stack_rd_data[ADDR_W-1:0];
          flag_wr.data = 1'b0;
          top_next = top_dec;
          popped_next = stack_rd_data;
        end
        ACT_QUERY, ACT_RSVD: begin
          is_member_next = flag_rd_data;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      top <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(SET_SIZE - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && !empty_pop) begin
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          top <= top_next;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act <= s_tuser;
      elem <= in_elem;
      if (empty_pop) begin
        popped <= '0;
        is_member <= 1'b0;
        depth <= top;
        status <= STAT_EMPTY;
      end
    end
    if (state == ST_LOOK) begin
      popped <= popped_next;
      is_member <= is_member_next;
      depth <= top_next;
      status <= status_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    top <= DEPTH_W'(SET_SIZE))
    else $error("stack depth exceeds the set size");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !s_tready)
    else $error("input accepted during the clearing pass");

  a_look_output_free: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOOK |-> !m_tvalid)
    else $error("output register occupied while a result is being formed");

  a_empty_means_zero_depth: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status == STAT_EMPTY) |-> (depth == '0) && (popped == '0))
    else $error("empty-stack status with nonzero depth or element");
`endif

endmodule

`default_nettype wire
